### design/tbp_pkg.sv
package tbp_pkg;

  localparam int GLOBAL_HIST_BITS_DEF = 12;
  localparam int LOCAL_HIST_BITS_DEF  = 10;
  localparam int ADDR_INDEX_BITS_DEF  = 10;
  localparam int ADDR_BITS            = 32;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MAX          = 2'd3;
  localparam ctr_t CTR_MIN          = 2'd0;
  localparam ctr_t GLOBAL_CTR_RESET = 2'd1;
  localparam ctr_t CHOICE_CTR_RESET = 2'd0;
  localparam ctr_t LOCAL_CTR_RESET  = 2'd0;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_TRAIN   = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [ADDR_BITS-1:0] branch_address;
    logic                 resolved_taken;
  } tbp_in_t;

  typedef struct packed {
    logic predict_taken;
    logic used_global;
  } tbp_out_t;

  typedef struct packed {
    logic local_pred;
    logic global_pred;
    logic use_global;
    logic pred;
    ctr_t choice_nxt;
    ctr_t global_nxt;
    ctr_t local_nxt;
  } tbp_upd_t;

  function automatic ctr_t sat_move(ctr_t ctr, logic up);
    ctr_t res;
    if (up) begin
      res = (ctr == CTR_MAX) ? ctr : ctr + 2'd1;
    end else begin
      res = (ctr == CTR_MIN) ? ctr : ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

### design/tournament_branch_predictor.sv
// Channel   Ports                     Transaction
// input     start, busy, in_data      taken at an edge with start high and busy low
// result    out_valid, out_data       one cycle strobe, one result per input
//
// The result strobe rises after the lookup has passed through S_RD1 and S_RD2. The
// block takes no new item until that result is out: the next item can be accepted at
// the edge that ends that strobe. The sequence is set by the dependent reads: local
// history RAM, then local counter RAM, then write-back.
// After reset busy stays high while the clear counter, max(GLOBAL_HIST_BITS,
// LOCAL_HIST_BITS, ADDR_INDEX_BITS) bits wide, sweeps every table to its reset value.
// The receiver cannot stall; results are never held back.
module tournament_branch_predictor #(
  parameter int GLOBAL_HIST_BITS = tbp_pkg::GLOBAL_HIST_BITS_DEF,
  parameter int LOCAL_HIST_BITS  = tbp_pkg::LOCAL_HIST_BITS_DEF,
  parameter int ADDR_INDEX_BITS  = tbp_pkg::ADDR_INDEX_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  tbp_pkg::tbp_in_t in_data,
  output logic             out_valid,
  output tbp_pkg::tbp_out_t out_data
);
  import tbp_pkg::*;

  localparam int G = GLOBAL_HIST_BITS;
  localparam int L = LOCAL_HIST_BITS;
  localparam int A = ADDR_INDEX_BITS;
  localparam int CLR_BITS = (G > L) ? ((G > A) ? G : A) : ((L > A) ? L : A);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RD1   = 4'b0100,
    S_RD2   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CLR_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [G-1:0]        ghist_r, ghist_nxt;
  logic                opcode_r;
  logic                taken_r;
  logic [A-1:0]        aidx_r;
  logic                out_valid_r, out_valid_nxt;
  tbp_out_t            out_data_r;

  logic                accept;
  logic                train_wb;
  logic                clearing;

  logic                gc_we;
  logic [G-1:0]        gc_waddr;
  logic [3:0]          gc_wdata;
  logic [3:0]          gc_rdata;
  logic                lh_we;
  logic [A-1:0]        lh_waddr;
  logic [L-1:0]        lh_wdata;
  logic [L-1:0]        lh_rdata;
  logic                lc_we;
  logic [L-1:0]        lc_waddr;
  ctr_t                lc_wdata;
  ctr_t                lc_rdata;

  tbp_upd_t            upd;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign clearing = (state_r == S_CLEAR);
  assign train_wb = (state_r == S_RD2) && (opcode_r == OP_TRAIN);

  always_comb begin
    if (clearing) begin
      gc_we    = 1'b1;
      gc_waddr = clr_cnt_r[G-1:0];
      gc_wdata = {CHOICE_CTR_RESET, GLOBAL_CTR_RESET};
      lh_we    = 1'b1;
      lh_waddr = clr_cnt_r[A-1:0];
      lh_wdata = '0;
      lc_we    = 1'b1;
      lc_waddr = clr_cnt_r[L-1:0];
      lc_wdata = LOCAL_CTR_RESET;
    end else begin
      gc_we    = train_wb;
      gc_waddr = ghist_r;
      gc_wdata = {upd.choice_nxt, upd.global_nxt};
      lh_we    = train_wb;
      lh_waddr = aidx_r;
      lh_wdata = {lh_rdata[L-2:0], taken_r};
      lc_we    = train_wb;
      lc_waddr = lh_rdata;
      lc_wdata = upd.local_nxt;
    end
  end

  tbp_ram #(.WIDTH(4), .DEPTH(1 << G)) u_gc_ram (
    .clk   (clk),
    .we    (gc_we),
    .waddr (gc_waddr),
    .wdata (gc_wdata),
    .re    (accept),
    .raddr (ghist_r),
    .rdata (gc_rdata)
  );

  tbp_ram #(.WIDTH(L), .DEPTH(1 << A)) u_lh_ram (
    .clk   (clk),
    .we    (lh_we),
    .waddr (lh_waddr),
    .wdata (lh_wdata),
    .re    (accept),
    .raddr (in_data.branch_address[A-1:0]),
    .rdata (lh_rdata)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(1 << L)) u_lc_ram (
    .clk   (clk),
    .we    (lc_we),
    .waddr (lc_waddr),
    .wdata (lc_wdata),
    .re    (state_r == S_RD1),
    .raddr (lh_rdata),
    .rdata (lc_rdata)
  );

  tbp_train u_train (
    .global_ctr (gc_rdata[1:0]),
    .choice_ctr (gc_rdata[3:2]),
    .local_ctr  (lc_rdata),
    .taken      (taken_r),
    .upd        (upd)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    ghist_nxt     = ghist_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CLR_BITS'(1);
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        out_valid_nxt = 1'b1;
        if (train_wb) begin
          ghist_nxt = {ghist_r[G-2:0], taken_r};
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      ghist_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ghist_r     <= ghist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_r <= in_data.opcode;
      taken_r  <= in_data.resolved_taken;
      aidx_r   <= in_data.branch_address[A-1:0];
    end
    if (state_r == S_RD2) begin
      out_data_r.predict_taken <= upd.pred;
      out_data_r.used_global   <= upd.use_global;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_follows_rd2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_RD2))
    else $error("result strobe without a finished lookup");

  a_rd1_to_rd2: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD1) |=> (state_r == S_RD2))
    else $error("lookup sequence broken");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result strobe during table sweep");

  a_ghist_train_only: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(ghist_r)) |->
      $past((state_r == S_RD2) && (opcode_r == OP_TRAIN)))
    else $error("global history changed outside a training transaction");

endmodule

### design/tbp_ram.sv
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/tbp_train.sv
module tbp_train (
  input  tbp_pkg::ctr_t     global_ctr,
  input  tbp_pkg::ctr_t     choice_ctr,
  input  tbp_pkg::ctr_t     local_ctr,
  input  logic              taken,
  output tbp_pkg::tbp_upd_t upd
);
  import tbp_pkg::*;

  logic g_ok;
  logic l_ok;

  always_comb begin
    upd             = '0;
    upd.local_pred  = local_ctr[1];
    upd.global_pred = global_ctr[1];
    upd.use_global  = choice_ctr[1];
    upd.pred        = upd.use_global ? upd.global_pred : upd.local_pred;

    g_ok = (upd.global_pred == taken);
    l_ok = (upd.local_pred == taken);
    if (g_ok && !l_ok) begin
      upd.choice_nxt = sat_move(choice_ctr, 1'b1);
    end else if (!g_ok && l_ok) begin
      upd.choice_nxt = sat_move(choice_ctr, 1'b0);
    end else begin
      upd.choice_nxt = choice_ctr;
    end
    upd.global_nxt = sat_move(global_ctr, taken);
    upd.local_nxt  = sat_move(local_ctr, taken);
  end

endmodule

### bench/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbp_pkg::*;

  localparam int GHB = GLOBAL_HIST_BITS_DEF;
  localparam int LHB = LOCAL_HIST_BITS_DEF;
  localparam int AIB = ADDR_INDEX_BITS_DEF;
  localparam int RANDOM_ITEMS = 850;
  localparam int CALM_TAIL = 120;
  localparam int SETTLE_CYCLES = 8;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  tbp_in_t  in_data = '0;
  logic     out_valid;
  tbp_out_t out_data;

  tournament_branch_predictor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the predictor tables.
  logic [GHB-1:0] ghist;
  ctr_t           gctr [0:(1<<GHB)-1];
  ctr_t           choice [0:(1<<GHB)-1];
  logic [LHB-1:0] lhist [0:(1<<AIB)-1];
  ctr_t           lctr [0:(1<<LHB)-1];

  tbp_in_t  pending_items [$];
  tbp_out_t predictions_due [$];
  int       drain_marks [$];

  int n_total;
  int n_launched;
  int n_trained;
  int n_peeked;
  int n_results;
  int n_global_used;
  int n_taken_pred;
  int n_errors;
  int idle_left;
  int idle_pct;

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic ctr_t nudge(ctr_t c, logic up);
    if (up) begin
      return (c == CTR_MAX) ? c : c + 2'd1;
    end
    return (c == CTR_MIN) ? c : c - 2'd1;
  endfunction

  task automatic predict_branch(input tbp_in_t t);
    logic [AIB-1:0] a_idx;
    logic [LHB-1:0] l_idx;
    logic [GHB-1:0] g_idx;
    logic           local_says;
    logic           global_says;
    tbp_out_t       guess;
    a_idx = t.branch_address[AIB-1:0];
    l_idx = lhist[a_idx];
    g_idx = ghist;
    local_says = lctr[l_idx] > 2'd1;
    global_says = gctr[g_idx] > 2'd1;
    guess.used_global = choice[g_idx] > 2'd1;
    guess.predict_taken = guess.used_global ? global_says : local_says;
    predictions_due.push_back(guess);
    if (t.opcode == OP_TRAIN) begin
      n_trained++;
      if (global_says == t.resolved_taken && local_says != t.resolved_taken) begin
        choice[g_idx] = nudge(choice[g_idx], 1'b1);
      end else if (global_says != t.resolved_taken && local_says == t.resolved_taken) begin
        choice[g_idx] = nudge(choice[g_idx], 1'b0);
      end
      gctr[g_idx] = nudge(gctr[g_idx], t.resolved_taken);
      ghist = {ghist[GHB-2:0], t.resolved_taken};
      lctr[l_idx] = nudge(lctr[l_idx], t.resolved_taken);
      lhist[a_idx] = {lhist[a_idx][LHB-2:0], t.resolved_taken};
    end else begin
      n_peeked++;
    end
  endtask

  task automatic add_item(input logic op, input logic [31:0] addr, input logic taken);
    tbp_in_t t;
    t.opcode = op;
    t.branch_address = addr;
    t.resolved_taken = taken;
    pending_items.push_back(t);
  endtask

  task automatic fill_stimulus();
    logic [31:0] hot [0:15];
    logic [31:0] prog_addr [0:3];
    int          prog_kind [0:3];
    int          prog_period [0:3];
    logic        outcome;
    logic        last_outcome;
    int          n_directed;
    int          nb;
    int          reps;
    // Directed: field extremes, both operations, ignored outcome on predict,
    // aliasing of upper address bits, and counter saturation in both directions.
    add_item(OP_PREDICT, 32'h0000_0000, 1'b0);
    add_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b1);
    repeat (4) add_item(OP_TRAIN, 32'h0000_0000, 1'b1);
    repeat (3) add_item(OP_TRAIN, 32'hFFFF_FC00, 1'b0);
    add_item(OP_PREDICT, 32'h0000_0400, 1'b1);
    add_item(OP_TRAIN, 32'hFFFF_FFFF, 1'b1);
    add_item(OP_TRAIN, 32'hFFFF_FFFF, 1'b0);
    add_item(OP_TRAIN, 32'hAAAA_AAAA, 1'b1);
    add_item(OP_TRAIN, 32'h5555_5555, 1'b0);
    add_item(OP_PREDICT, 32'h5555_5555, 1'b0);
    repeat (6) add_item(OP_TRAIN, 32'h0000_03FF, 1'b1);
    add_item(OP_PREDICT, 32'h0000_03FF, 1'b0);
    add_item(OP_TRAIN, 32'h8000_0001, 1'b0);
    add_item(OP_PREDICT, 32'h8000_0001, 1'b1);
    n_directed = pending_items.size();
    drain_marks.push_back(n_directed);
    drain_marks.push_back(n_directed + $urandom_range(600, 200));

    foreach (hot[i]) hot[i] = $urandom;
    last_outcome = 1'b0;
    while (pending_items.size() < n_directed + RANDOM_ITEMS) begin
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(8, 1)) begin
          add_item(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
        end
      end else begin
        // A small loop body of branches with recognizable behavior.
        nb = $urandom_range(4, 1);
        for (int b = 0; b < nb; b++) begin
          prog_addr[b] = ($urandom_range(3) != 0) ? hot[$urandom_range(15)] : $urandom;
          prog_kind[b] = $urandom_range(4);
          prog_period[b] = $urandom_range(6, 2);
        end
        reps = $urandom_range(20, 4);
        for (int r = 0; r < reps; r++) begin
          for (int b = 0; b < nb; b++) begin
            case (prog_kind[b])
              0: outcome = 1'b1;
              1: outcome = 1'b0;
              2: outcome = r[0];
              3: outcome = (r % prog_period[b]) != prog_period[b] - 1;
              default: outcome = last_outcome;
            endcase
            if ($urandom_range(99) < 5) outcome = !outcome;
            if ($urandom_range(99) < 25) begin
              add_item(OP_PREDICT, prog_addr[b], 1'($urandom_range(1)));
            end
            add_item(OP_TRAIN, prog_addr[b], outcome);
            last_outcome = outcome;
          end
        end
      end
    end
    n_total = pending_items.size();
  endtask

  always @(posedge clk) begin : driver
    tbp_in_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_branch(in_data);
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_items.size() == 0) begin
          start <= 1'b0;
        end else if (drain_marks.size() != 0 && n_launched == drain_marks[0] &&
                     (predictions_due.size() != 0 || busy)) begin
          start <= 1'b0;
        end else begin
          if (drain_marks.size() != 0 && n_launched == drain_marks[0]) begin
            void'(drain_marks.pop_front());
          end
          nxt = pending_items.pop_front();
          in_data <= nxt;
          start <= 1'b1;
          n_launched++;
          if (n_launched % 64 == 0) begin
            case ($urandom_range(2))
              0: idle_pct = 0;
              1: idle_pct = 10;
              default: idle_pct = 35;
            endcase
          end
          if (n_launched < n_total - CALM_TAIL && $urandom_range(99) < idle_pct) begin
            idle_left = $urandom_range(16, 1);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    tbp_out_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (out_data.used_global) n_global_used++;
      if (out_data.predict_taken) n_taken_pred++;
      if (predictions_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no transaction outstanding",
                                  n_results));
      end else begin
        want = predictions_due.pop_front();
        if (out_data.predict_taken !== want.predict_taken) begin
          report_mismatch($sformatf("result %0d predict_taken got %b expected %b",
                                    n_results, out_data.predict_taken, want.predict_taken));
        end
        if (out_data.used_global !== want.used_global) begin
          report_mismatch($sformatf("result %0d used_global got %b expected %b",
                                    n_results, out_data.used_global, want.used_global));
        end
      end
    end
  end

  initial begin
    ghist = '0;
    foreach (gctr[i]) gctr[i] = GLOBAL_CTR_RESET;
    foreach (choice[i]) choice[i] = CHOICE_CTR_RESET;
    foreach (lhist[i]) lhist[i] = '0;
    foreach (lctr[i]) lctr[i] = LOCAL_CTR_RESET;
    n_launched = 0;
    n_trained = 0;
    n_peeked = 0;
    n_results = 0;
    n_global_used = 0;
    n_taken_pred = 0;
    n_errors = 0;
    idle_left = 0;
    idle_pct = 0;
    fill_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_items.size() != 0 || start || predictions_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predictions_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", predictions_due.size()));
    end
    $display("Covered %0d transactions: %0d training, %0d predict-only, %0d results checked.",
             n_launched, n_trained, n_peeked, n_results);
    $display("Results followed the global side %0d times and predicted taken %0d times.",
             n_global_used, n_taken_pred);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #250000;
    $display("Timed out with %0d items still pending and %0d results due.",
             pending_items.size(), predictions_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

### tournament_branch_predictor.f
design/tbp_pkg.sv
design/tbp_ram.sv
design/tbp_train.sv
design/tournament_branch_predictor.sv
bench/tb.sv
